// ===== rtl/core/lcdseq_pkg.sv =====
// Shared types, codes and the microprogram ROM of the character LCD bus sequencer.
// Depends on nothing; every other file of the block imports it.
package lcdseq_pkg;

   localparam int UC_AW = 5;

   // Action codes of an input item.
   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_CMD   = 2'd1;
   localparam logic [1:0] ACT_DATA  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Interface mode register values.
   localparam logic MODE_8BIT = 1'b0;
   localparam logic MODE_4BIT = 1'b1;

   // Microprogram entry points.
   localparam logic [UC_AW-1:0] UC_INIT     = 5'd0;
   localparam logic [UC_AW-1:0] UC_INIT4    = 5'd3;
   localparam logic [UC_AW-1:0] UC_INIT8    = 5'd14;
   localparam logic [UC_AW-1:0] UC_BYTE8    = 5'd19;
   localparam logic [UC_AW-1:0] UC_BYTE4    = 5'd20;

   // Wait values in microseconds (a millisecond counts as 1024 us).
   localparam logic [15:0] POWERUP_WAIT_US = 16'd51200;
   localparam logic [13:0] INIT_GAP_US     = 14'd10240;
   localparam logic [13:0] NIBBLE_GAP_US   = 14'd5120;
   localparam logic [13:0] WRITE_GAP_US    = 14'd2048;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic        reg_select;
      logic [7:0]  bus_value;
      logic [15:0] wait_before_us;
      logic [13:0] wait_after_us;
      logic        last;
   } rsp_type;

   typedef enum logic {
      SRC_CONST,
      SRC_VALUE
   } src_type;

   typedef enum logic [1:0] {
      NIB_FULL,
      NIB_HIGH,
      NIB_LOW
   } nib_type;

   typedef enum logic [1:0] {
      AFT_ZERO,
      AFT_INIT,
      AFT_NIBBLE,
      AFT_WRITE
   } after_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // One control word of the microprogram.
   typedef struct packed {
      src_type          src;
      nib_type          nib;
      logic [7:0]       byte_k;
      logic             pwr_wait;
      after_type        after;
      logic             last;
      logic             br_mode8;
      logic [UC_AW-1:0] target;
   } ucode_type;

   // Sequencer to datapath: one strobe to be formed this cycle.
   typedef struct packed {
      logic       fire;
      ucode_type  word;
      logic [7:0] value;
      logic       reg_select;
   } seq_ctl_type;

   function automatic ucode_type uc_word(input src_type src, input nib_type nib,
                                         input logic [7:0] byte_k, input logic pwr_wait,
                                         input after_type after, input logic last);
      ucode_type w;
      w.src      = src;
      w.nib      = nib;
      w.byte_k   = byte_k;
      w.pwr_wait = pwr_wait;
      w.after    = after;
      w.last     = last;
      w.br_mode8 = 1'b0;
      w.target   = '0;
      return w;
   endfunction

   // The microprogram. The third 0x30 strobe branches to the 8-bit tail
   // when the bus is in 8-bit mode.
   function automatic ucode_type uc_rom(input logic [UC_AW-1:0] pc);
      ucode_type w;
      w = uc_word(SRC_CONST, NIB_FULL, 8'h00, 1'b0, AFT_ZERO, 1'b1);
      unique case (pc)
         5'd0:  w = uc_word(SRC_CONST, NIB_FULL, 8'h30, 1'b1, AFT_INIT, 1'b0);
         5'd1:  w = uc_word(SRC_CONST, NIB_FULL, 8'h30, 1'b0, AFT_INIT, 1'b0);
         5'd2: begin
            w = uc_word(SRC_CONST, NIB_FULL, 8'h30, 1'b0, AFT_INIT, 1'b0);
            w.br_mode8 = 1'b1;
            w.target   = UC_INIT8;
         end
         5'd3:  w = uc_word(SRC_CONST, NIB_FULL, 8'h20, 1'b0, AFT_NIBBLE, 1'b0);
         5'd4:  w = uc_word(SRC_CONST, NIB_HIGH, 8'h28, 1'b0, AFT_ZERO, 1'b0);
         5'd5:  w = uc_word(SRC_CONST, NIB_LOW,  8'h28, 1'b0, AFT_INIT, 1'b0);
         5'd6:  w = uc_word(SRC_CONST, NIB_HIGH, 8'h08, 1'b0, AFT_ZERO, 1'b0);
         5'd7:  w = uc_word(SRC_CONST, NIB_LOW,  8'h08, 1'b0, AFT_INIT, 1'b0);
         5'd8:  w = uc_word(SRC_CONST, NIB_HIGH, 8'h01, 1'b0, AFT_ZERO, 1'b0);
         5'd9:  w = uc_word(SRC_CONST, NIB_LOW,  8'h01, 1'b0, AFT_INIT, 1'b0);
         5'd10: w = uc_word(SRC_CONST, NIB_HIGH, 8'h06, 1'b0, AFT_ZERO, 1'b0);
         5'd11: w = uc_word(SRC_CONST, NIB_LOW,  8'h06, 1'b0, AFT_INIT, 1'b0);
         5'd12: w = uc_word(SRC_CONST, NIB_HIGH, 8'h0F, 1'b0, AFT_ZERO, 1'b0);
         5'd13: w = uc_word(SRC_CONST, NIB_LOW,  8'h0F, 1'b0, AFT_INIT, 1'b1);
         5'd14: w = uc_word(SRC_CONST, NIB_FULL, 8'h38, 1'b0, AFT_INIT, 1'b0);
         5'd15: w = uc_word(SRC_CONST, NIB_FULL, 8'h08, 1'b0, AFT_INIT, 1'b0);
         5'd16: w = uc_word(SRC_CONST, NIB_FULL, 8'h01, 1'b0, AFT_INIT, 1'b0);
         5'd17: w = uc_word(SRC_CONST, NIB_FULL, 8'h06, 1'b0, AFT_INIT, 1'b0);
         5'd18: w = uc_word(SRC_CONST, NIB_FULL, 8'h0F, 1'b0, AFT_INIT, 1'b1);
         5'd19: w = uc_word(SRC_VALUE, NIB_FULL, 8'h00, 1'b0, AFT_WRITE, 1'b1);
         5'd20: w = uc_word(SRC_VALUE, NIB_HIGH, 8'h00, 1'b0, AFT_ZERO, 1'b0);
         5'd21: w = uc_word(SRC_VALUE, NIB_LOW,  8'h00, 1'b0, AFT_WRITE, 1'b1);
         default: w = uc_word(SRC_CONST, NIB_FULL, 8'h00, 1'b0, AFT_ZERO, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/lcdseq_ucode_seq.sv =====
// Microprogram sequencer: step counter, dispatch on accept, conditional branch.
// Depends on lcdseq_pkg for the control word, ROM and codes.
module lcdseq_ucode_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lcdseq_pkg::req_type   req_item,
   input  logic                  mode,
   output logic                  busy,
   output lcdseq_pkg::seq_ctl_type ctl
);
   import lcdseq_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [UC_AW-1:0] pc_ff, pc_in;
   logic [7:0]       value_ff;
   logic             rs_ff;
   logic             accept;
   ucode_type        word;

   assign word   = uc_rom(pc_ff);
   assign accept = start && (state_ff == SEQ_IDLE) && (req_item.action != ACT_NONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (accept) state_in = SEQ_RUN;
         SEQ_RUN:  if (word.last) state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      ctl.fire  = 1'b0;
      ctl.word  = word;
      ctl.value = value_ff;
      ctl.reg_select = rs_ff;
      unique case (state_ff)
         SEQ_IDLE: busy = 1'b0;
         SEQ_RUN: begin
            busy     = 1'b1;
            ctl.fire = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   // Entry point on accept; otherwise step or take the 8-bit branch.
   always_comb begin
      pc_in = pc_ff;
      if (accept) begin
         if (req_item.action == ACT_INIT) begin
            pc_in = UC_INIT;
         end else if (mode == MODE_4BIT) begin
            pc_in = UC_BYTE4;
         end else begin
            pc_in = UC_BYTE8;
         end
      end else if (state_ff == SEQ_RUN) begin
         if (word.br_mode8 && (mode == MODE_8BIT)) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= req_item.value;
         rs_ff    <= (req_item.action == ACT_DATA);
      end
   end

endmodule

// ===== rtl/core/lcdseq_datapath.sv =====
// Strobe datapath: forms one result item from a control word and registers it.
// Depends on lcdseq_pkg for the control and result types.
module lcdseq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdseq_pkg::seq_ctl_type ctl,
   output logic                    rsp_valid,
   output lcdseq_pkg::rsp_type     rsp_item
);
   import lcdseq_pkg::*;

   logic       rsp_valid_ff;
   rsp_type    rsp_item_ff, rsp_item_in;
   logic [7:0] src_byte;

   always_comb begin
      src_byte = (ctl.word.src == SRC_VALUE) ? ctl.value : ctl.word.byte_k;
      rsp_item_in.reg_select     = ctl.reg_select;
      rsp_item_in.last           = ctl.word.last;
      rsp_item_in.wait_before_us = ctl.word.pwr_wait ? POWERUP_WAIT_US : 16'd0;
      unique case (ctl.word.nib)
         NIB_FULL: rsp_item_in.bus_value = src_byte;
         NIB_HIGH: rsp_item_in.bus_value = {src_byte[7:4], 4'h0};
         NIB_LOW:  rsp_item_in.bus_value = {src_byte[3:0], 4'h0};
         default:  rsp_item_in.bus_value = src_byte;
      endcase
      unique case (ctl.word.after)
         AFT_ZERO:   rsp_item_in.wait_after_us = 14'd0;
         AFT_INIT:   rsp_item_in.wait_after_us = INIT_GAP_US;
         AFT_NIBBLE: rsp_item_in.wait_after_us = NIBBLE_GAP_US;
         AFT_WRITE:  rsp_item_in.wait_after_us = WRITE_GAP_US;
         default:    rsp_item_in.wait_after_us = 14'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.fire;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/core/lcd_char_bus_sequencer_core.sv =====
// Top level of the character LCD bus sequencer: mode register, sequencer, datapath.
// Depends on lcdseq_pkg, lcdseq_ucode_seq and lcdseq_datapath.
//
//   Channel   Ports                          Handshake
//   --------  -----------------------------  ------------------------------------
//   request   start, busy, req_item          taken when start is high, busy low
//   response  rsp_valid, rsp_item            each strobe shown for one cycle, no stall
//   csr       csr_wr_en, csr_wr_data         written on any edge with csr_wr_en
//
// An accepted action produces its strobes one per cycle: 1 for a byte in 8-bit
// mode, 2 in 4-bit mode, 8 or 14 for initialisation. The first strobe reaches the
// result ports through the sequencer state register and the datapath register.
// The microprogram counter advances once per strobe, and busy stays high while
// the item's strobes are issued. Busy drops on the edge that shows the last
// strobe, so the next item can be taken at the end of that same cycle. Action
// code three is taken and produces nothing, and busy stays low. Reset is
// synchronous and returns the block to idle in 8-bit mode. Results cannot be
// held off by the receiver.
module lcd_char_bus_sequencer_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lcdseq_pkg::req_type req_item,
   output logic                rsp_valid,
   output lcdseq_pkg::rsp_type rsp_item,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);
   import lcdseq_pkg::*;

   // Interface mode: 0 selects the 8-bit bus, 1 the 4-bit nibble bus.
   logic        mode_ff;
   seq_ctl_type ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_8BIT;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // The sequencer walks the microprogram and issues one control word a cycle.
   lcdseq_ucode_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .mode     (mode_ff),
      .busy     (busy),
      .ctl      (ctl)
   );

   // The datapath turns each control word into a registered result item.
   lcdseq_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/core/lcdseq_checker.sv =====
// Port-level checks of the character LCD bus sequencer, bound to the top level.
// Depends on lcdseq_pkg and lcd_char_bus_sequencer_core.
module lcdseq_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input lcdseq_pkg::req_type req_item,
   input logic                rsp_valid,
   input lcdseq_pkg::rsp_type rsp_item,
   input logic                csr_wr_en,
   input logic                csr_wr_data
);
   import lcdseq_pkg::*;

   // Strobes of one item come back to back.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> rsp_valid)
      else $error("strobe sequence broken before last");

   // Busy covers exactly the strobes that are not last.
   a_busy_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy == !rsp_item.last))
      else $error("busy disagrees with last flag");

   // No strobe in the cycle right after an accept.
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("strobe right after accept");

   // Initialise always starts work.
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.action == ACT_INIT) |=> busy)
      else $error("initialise not started");

   // The power-up wait only ever precedes a command strobe of 0x30.
   a_powerup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.wait_before_us != 16'd0) |->
         (rsp_item.bus_value == 8'h30) && !rsp_item.reg_select && !rsp_item.last)
      else $error("power-up wait on wrong strobe");

endmodule

bind lcd_char_bus_sequencer_core lcdseq_checker u_lcdseq_checker (.*);

// ===== verif/lcd_char_bus_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lcd_char_bus_sequencer_core: it drives actions, predicts the
// enable strobes of each one and compares every strobe as it appears on the response port.
// Depends on lcdseq_pkg and the RTL of the sequencer core.
module lcd_char_bus_sequencer_core_tb;
   import lcdseq_pkg::*;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_item    = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Actions waiting to be offered, and strobes predicted but not yet seen.
   req_type pending_actions[$];
   rsp_type expected_strobes[$];

   // Shadow of the interface mode register. It only changes while the block is idle.
   logic bus_mode = MODE_8BIT;

   // Chance in percent that the driver leaves start low in a cycle where it could offer an item.
   int idle_pct = 0;

   int error_count     = 0;
   int strobes_checked = 0;
   int init_count      = 0;
   int write_count     = 0;
   int ignored_count   = 0;

   lcd_char_bus_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Strobe prediction. Each accepted action expands into its list of strobes here, in the
   // order the display must see them. The last flag is set on the final strobe afterwards.
   // ---------------------------------------------------------------------------------------
   function automatic void push_strobe(input logic rs, input logic [7:0] bus,
                                       input logic [15:0] pre_wait, input logic [13:0] after);
      rsp_type s;
      s.reg_select     = rs;
      s.bus_value      = bus;
      s.wait_before_us = pre_wait;
      s.wait_after_us  = after;
      s.last           = 1'b0;
      expected_strobes.push_back(s);
   endfunction

   // A byte is one strobe on the 8-bit bus. On the 4-bit bus it goes out as the high nibble
   // with no wait after it, then the low nibble, both on D7..D4 with D3..D0 held at zero.
   function automatic void push_byte(input logic rs, input logic [7:0] b,
                                     input logic [13:0] after);
      if (bus_mode == MODE_8BIT) begin
         push_strobe(rs, b, 16'd0, after);
      end else begin
         push_strobe(rs, {b[7:4], 4'h0}, 16'd0, 14'd0);
         push_strobe(rs, {b[3:0], 4'h0}, 16'd0, after);
      end
   endfunction

   // Bytes of the power-up table that follow the three wake-up strobes. Only the function
   // set byte depends on the bus width.
   function automatic logic [7:0] init_tail_byte(input int i);
      case (i)
         0:       return (bus_mode == MODE_8BIT) ? 8'h38 : 8'h28;
         1:       return 8'h08;
         2:       return 8'h01;
         3:       return 8'h06;
         default: return 8'h0F;
      endcase
   endfunction

   function automatic void predict_strobes(input req_type item);
      rsp_type closing;
      case (item.action)
         ACT_INIT: begin
            // Three wake-up strobes of 0x30, the first after the long power-up wait.
            push_strobe(1'b0, 8'h30, POWERUP_WAIT_US, INIT_GAP_US);
            push_strobe(1'b0, 8'h30, 16'd0, INIT_GAP_US);
            push_strobe(1'b0, 8'h30, 16'd0, INIT_GAP_US);
            // The 4-bit bus needs one extra full strobe to switch the width over.
            if (bus_mode == MODE_4BIT) begin
               push_strobe(1'b0, 8'h20, 16'd0, NIBBLE_GAP_US);
            end
            for (int i = 0; i < 5; i++) begin
               push_byte(1'b0, init_tail_byte(i), INIT_GAP_US);
            end
         end
         ACT_CMD:  push_byte(1'b0, item.value, WRITE_GAP_US);
         ACT_DATA: push_byte(1'b1, item.value, WRITE_GAP_US);
         default:  return;   // The unused code is taken and produces nothing.
      endcase
      closing = expected_strobes.pop_back();
      closing.last = 1'b1;
      expected_strobes.push_back(closing);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver. Items come from pending_actions. An item is taken at an edge where start is high
   // and busy is low; the prediction is made at that same edge. Start stays high across
   // back-to-back items, and drops only when the queue is empty or an idle cycle is drawn.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_strobes(req_item);
            case (req_item.action)
               ACT_INIT:         init_count++;
               ACT_CMD, ACT_DATA: write_count++;
               default:          ignored_count++;
            endcase
         end
         // A new item may be offered when nothing is on offer or the offer was just taken.
         if (!start || !busy) begin
            if (pending_actions.size() > 0 && $urandom_range(99) >= idle_pct) begin
               start    <= 1'b1;
               req_item <= pending_actions.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor. Each strobe is valid for exactly one cycle and cannot be held off, so it is
   // taken at every edge where rsp_valid is high and matched against the oldest prediction.
   // ---------------------------------------------------------------------------------------
   function automatic void check_strobe(input rsp_type exp_s, input rsp_type act_s);
      if (act_s.reg_select !== exp_s.reg_select) begin
         $error("reg_select: expected %0d, got %0d", exp_s.reg_select, act_s.reg_select);
         error_count++;
      end
      if (act_s.bus_value !== exp_s.bus_value) begin
         $error("bus_value: expected %02h, got %02h", exp_s.bus_value, act_s.bus_value);
         error_count++;
      end
      if (act_s.wait_before_us !== exp_s.wait_before_us) begin
         $error("wait_before_us: expected %0d, got %0d",
                exp_s.wait_before_us, act_s.wait_before_us);
         error_count++;
      end
      if (act_s.wait_after_us !== exp_s.wait_after_us) begin
         $error("wait_after_us: expected %0d, got %0d",
                exp_s.wait_after_us, act_s.wait_after_us);
         error_count++;
      end
      if (act_s.last !== exp_s.last) begin
         $error("last: expected %0d, got %0d", exp_s.last, act_s.last);
         error_count++;
      end
      strobes_checked++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_strobes.size() == 0) begin
            $error("strobe with nothing predicted: bus_value %02h, reg_select %0d",
                   rsp_item.bus_value, rsp_item.reg_select);
            error_count++;
         end else begin
            check_strobe(expected_strobes.pop_front(), rsp_item);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   task automatic queue_action(input logic [1:0] action, input logic [7:0] value);
      req_type item;
      item.action = action;
      item.value  = value;
      pending_actions.push_back(item);
   endtask

   // Waits until every item has been taken and every predicted strobe has been seen. An
   // ignored action can still be in flight then, so the task waits on before it returns;
   // strobes follow the accept edge through the sequencer and the datapath registers.
   task automatic drain();
      while (pending_actions.size() != 0 || start || busy || expected_strobes.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   // The mode register is only written once the block is idle.
   task automatic write_mode(input logic mode);
      drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      bus_mode = mode;
   endtask

   // Random items: mostly command and data writes with random bytes, some power-up sequences
   // and a few of the unused code, which the block must swallow without output.
   task automatic random_phase(input logic mode, input int pct, input int n);
      int pick;
      write_mode(mode);
      idle_pct = pct;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            queue_action(ACT_INIT, 8'($urandom_range(255)));
         end else if (pick < 15) begin
            queue_action(ACT_NONE, 8'($urandom_range(255)));
         end else if (pick < 58) begin
            queue_action(ACT_CMD, 8'($urandom_range(255)));
         end else begin
            queue_action(ACT_DATA, 8'($urandom_range(255)));
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, 8-bit bus, no idle cycles: the power-up table, both byte kinds at the
      // value extremes, and the unused code between writes.
      write_mode(MODE_8BIT);
      idle_pct = 0;
      queue_action(ACT_INIT, 8'h00);
      queue_action(ACT_CMD,  8'h00);
      queue_action(ACT_CMD,  8'hFF);
      queue_action(ACT_DATA, 8'h00);
      queue_action(ACT_DATA, 8'hFF);
      queue_action(ACT_NONE, 8'hFF);
      queue_action(ACT_DATA, 8'h5A);
      queue_action(ACT_CMD,  8'hA5);

      // Directed, 4-bit bus with idle cycles: nibble splitting of both halves, the longer
      // power-up table, and the unused code right before it.
      write_mode(MODE_4BIT);
      idle_pct = 48;
      queue_action(ACT_INIT, 8'hFF);
      queue_action(ACT_CMD,  8'h00);
      queue_action(ACT_CMD,  8'hFF);
      queue_action(ACT_DATA, 8'hF0);
      queue_action(ACT_DATA, 8'h0F);
      queue_action(ACT_DATA, 8'hA5);
      queue_action(ACT_NONE, 8'h00);
      queue_action(ACT_INIT, 8'h00);

      // Random phases alternate the bus width and the sender's idle rate.
      random_phase(MODE_8BIT, 0,  16);
      random_phase(MODE_4BIT, 48, 16);
      random_phase(MODE_8BIT, 17, 16);
      random_phase(MODE_4BIT, 0,  16);
      random_phase(MODE_8BIT, 48, 16);
      random_phase(MODE_4BIT, 17, 16);

      drain();
      repeat (10) @(posedge clock);

      $display("Covered %0d power-up, %0d command or data and %0d unused-code actions",
               init_count, write_count, ignored_count);
      $display("on both bus widths; %0d strobes compared, %0d field errors.",
               strobes_checked, error_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: a correct run ends well before this time limit, so this only fires on a hang or on
   // strobes that never arrive.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
